### design/plls_pkg.sv
// Shared types and constants for the probe least-loaded selector.
// Used by plls_cell and probe_least_loaded_selector; no dependencies.
package plls_pkg;

	localparam int KIND_W     = 3;
	localparam int ENTRY_W    = 3;
	localparam int NUM_NB_W   = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register index lives in paddr[2]
	localparam logic CFG_REG_NUM_NEIGHBORS = 1'b0;
	localparam logic [NUM_NB_W-1:0] NUM_NB_RESET = 4'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_START    = 3'd0,
		KIND_SET_PORT = 3'd1,
		KIND_RESPONSE = 3'd2,
		KIND_FORCE    = 3'd3,
		KIND_SELECT   = 3'd4
	} kind_t;

	// operation broadcast to every cell for the word in flight
	typedef struct packed {
		logic clear;
		logic set_port;
		logic resp;
	} cell_op_t;

	// token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
		logic all_ans;
		logic hi_valid;
		logic lo_valid;
	} tok_t;

endpackage

### design/plls_cell.sv
// One neighbor slot: port entry, load, answered mark, and the running
// minimum trackers passed to the next cell. Depends on plls_pkg.
module plls_cell #(
	parameter int IDX           = 0,
	parameter int MAX_NEIGHBORS = 8,
	parameter int PORT_BITS     = 16,
	parameter int LOAD_BITS     = 16,
	localparam int NW = $clog2(MAX_NEIGHBORS + 1),
	localparam int RW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plls_pkg::cell_op_t               op,
	input  logic [plls_pkg::ENTRY_W-1:0]     entry_index,
	input  logic [PORT_BITS-1:0]             port_id,
	input  logic [LOAD_BITS-1:0]             load_value,
	input  logic [NW-1:0]                    n_slots,
	input  logic [RW-1:0]                    start,
	input  plls_pkg::tok_t                   tok_in,
	input  logic [LOAD_BITS-1:0]             hi_min_in,
	input  logic [PORT_BITS-1:0]             hi_port_in,
	input  logic [LOAD_BITS-1:0]             lo_min_in,
	input  logic [PORT_BITS-1:0]             lo_port_in,
	output plls_pkg::tok_t                   tok_out,
	output logic [LOAD_BITS-1:0]             hi_min_out,
	output logic [PORT_BITS-1:0]             hi_port_out,
	output logic [LOAD_BITS-1:0]             lo_min_out,
	output logic [PORT_BITS-1:0]             lo_port_out
);

	logic [PORT_BITS-1:0] port_q;
	logic [LOAD_BITS-1:0] load_q;
	logic                 ans_q;

	plls_pkg::tok_t       tok_q;
	logic [LOAD_BITS-1:0] hi_min_q;
	logic [PORT_BITS-1:0] hi_port_q;
	logic [LOAD_BITS-1:0] lo_min_q;
	logic [PORT_BITS-1:0] lo_port_q;

	logic                 in_use;
	logic                 upper;
	logic                 hit;
	logic                 ans_n;
	logic [LOAD_BITS-1:0] load_n;
	logic                 take_hi;
	logic                 take_lo;

	assign in_use  = NW'(IDX) < n_slots;
	assign upper   = RW'(IDX) >= start;
	assign hit     = op.resp && in_use && !tok_in.found && (port_q == port_id);
	assign ans_n   = op.clear ? 1'b0 : (ans_q | hit);
	assign load_n  = hit ? load_value : load_q;
	assign take_hi = in_use && ans_n && upper && (!tok_in.hi_valid || load_n < hi_min_in);
	assign take_lo = in_use && ans_n && !upper && (!tok_in.lo_valid || load_n < lo_min_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			ans_q <= 1'b0;
		end else begin
			tok_q.valid    <= tok_in.valid;
			tok_q.found    <= tok_in.found | hit;
			tok_q.all_ans  <= tok_in.all_ans & (ans_n | !in_use);
			tok_q.hi_valid <= tok_in.hi_valid | take_hi;
			tok_q.lo_valid <= tok_in.lo_valid | take_lo;
			if (tok_in.valid) begin
				ans_q <= ans_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid && hit) begin
			load_q <= load_value;
		end
		if (tok_in.valid && op.set_port && (int'(entry_index) == IDX)) begin
			port_q <= port_id;
		end
		hi_min_q  <= take_hi ? load_n : hi_min_in;
		hi_port_q <= take_hi ? port_q : hi_port_in;
		lo_min_q  <= take_lo ? load_n : lo_min_in;
		lo_port_q <= take_lo ? port_q : lo_port_in;
	end

	assign tok_out     = tok_q;
	assign hi_min_out  = hi_min_q;
	assign hi_port_out = hi_port_q;
	assign lo_min_out  = lo_min_q;
	assign lo_port_out = lo_port_q;

endmodule

### design/probe_least_loaded_selector.sv
// Probe least-loaded selector: a row of MAX_NEIGHBORS slot cells that a
// token walks through, one cell per cycle. Depends on plls_pkg, plls_cell.
//
// Each input word (start, set port, response, force, select) is taken when
// the block is idle and sent down the cell row; every cell updates its slot
// as the token passes and folds its load into the running minimum. One
// result word comes out per input word; no new word is taken until the
// result of the last one has been handed to the output. A select issued
// after num_neighbors was lowered below the rotation point stays in the
// wrap state, subtracting the slot count from the rotation until it is
// back in range. num_neighbors is written through the APB port at byte
// address 0; 0 acts as 1 and values above MAX_NEIGHBORS act as
// MAX_NEIGHBORS.
module probe_least_loaded_selector #(
	parameter int MAX_NEIGHBORS = 8,
	parameter int PORT_BITS     = 16,
	parameter int LOAD_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [plls_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [plls_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [plls_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [plls_pkg::KIND_W-1:0]         kind,
	input  logic [plls_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [PORT_BITS-1:0]                port_id,
	input  logic [LOAD_BITS-1:0]                load_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                probe_complete,
	output logic [LOAD_BITS-1:0]                lowest_load,
	output logic                                lowest_valid,
	output logic [PORT_BITS-1:0]                chosen_port,
	output logic                                chosen_valid
);

	localparam int NW = $clog2(MAX_NEIGHBORS + 1);
	localparam int RW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRAP,
		ST_PASS,
		ST_EMIT
	} state_t;

	state_t                                state_q;
	logic [plls_pkg::NUM_NB_W-1:0]         num_q;
	plls_pkg::kind_t                       kind_q;
	logic [NW-1:0]                         n_q;
	logic [RW-1:0]                         rot_q;
	logic                                  complete_q;
	logic                                  ovalid_q;

	logic [plls_pkg::ENTRY_W-1:0]          item_entry_q;
	logic [PORT_BITS-1:0]                  item_port_q;
	logic [LOAD_BITS-1:0]                  item_load_q;

	logic [LOAD_BITS-1:0]                  res_load_q;
	logic                                  res_lvalid_q;
	logic [PORT_BITS-1:0]                  res_port_q;
	logic                                  res_cvalid_q;

	logic                                  probe_complete_q;
	logic [LOAD_BITS-1:0]                  lowest_load_q;
	logic                                  lowest_valid_q;
	logic [PORT_BITS-1:0]                  chosen_port_q;
	logic                                  chosen_valid_q;

	plls_pkg::tok_t                        tok_w [0:MAX_NEIGHBORS];
	logic [LOAD_BITS-1:0]                  hi_min_w [0:MAX_NEIGHBORS];
	logic [PORT_BITS-1:0]                  hi_port_w [0:MAX_NEIGHBORS];
	logic [LOAD_BITS-1:0]                  lo_min_w [0:MAX_NEIGHBORS];
	logic [PORT_BITS-1:0]                  lo_port_w [0:MAX_NEIGHBORS];

	plls_pkg::cell_op_t                    op;
	plls_pkg::tok_t                        tok_end;
	logic [NW-1:0]                         n_clamp;
	logic                                  wrap_need;
	logic [NW-1:0]                         rot_inc;
	logic [RW-1:0]                         rot_next;
	logic                                  pick_hi;
	logic                                  any_end;
	logic                                  cplt_n;
	logic                                  emit_go;
	logic                                  cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= plls_pkg::NUM_NB_RESET;
		end else if (cfg_wr && (paddr[2] == plls_pkg::CFG_REG_NUM_NEIGHBORS)) begin
			num_q <= pwdata[plls_pkg::NUM_NB_W-1:0];
		end
	end

	assign prdata = (paddr[2] == plls_pkg::CFG_REG_NUM_NEIGHBORS) ?
		plls_pkg::CFG_DATA_W'(num_q) : '0;

	always_comb begin
		if (num_q == '0) begin
			n_clamp = NW'(1);
		end else if (int'(num_q) > MAX_NEIGHBORS) begin
			n_clamp = NW'(MAX_NEIGHBORS);
		end else begin
			n_clamp = NW'(num_q);
		end
	end

	// cell row
	assign op.clear    = (kind_q == plls_pkg::KIND_START);
	assign op.set_port = (kind_q == plls_pkg::KIND_SET_PORT);
	assign op.resp     = (kind_q == plls_pkg::KIND_RESPONSE);

	assign wrap_need = (kind_q == plls_pkg::KIND_SELECT) && (NW'(rot_q) >= n_q);

	assign tok_w[0].valid    = (state_q == ST_WRAP) && !wrap_need;
	assign tok_w[0].found    = 1'b0;
	assign tok_w[0].all_ans  = 1'b1;
	assign tok_w[0].hi_valid = 1'b0;
	assign tok_w[0].lo_valid = 1'b0;
	assign hi_min_w[0]       = '0;
	assign hi_port_w[0]      = '0;
	assign lo_min_w[0]       = '0;
	assign lo_port_w[0]      = '0;

	for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
		plls_cell #(
			.IDX           (i),
			.MAX_NEIGHBORS (MAX_NEIGHBORS),
			.PORT_BITS     (PORT_BITS),
			.LOAD_BITS     (LOAD_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.entry_index (item_entry_q),
			.port_id     (item_port_q),
			.load_value  (item_load_q),
			.n_slots     (n_q),
			.start       (rot_q),
			.tok_in      (tok_w[i]),
			.hi_min_in   (hi_min_w[i]),
			.hi_port_in  (hi_port_w[i]),
			.lo_min_in   (lo_min_w[i]),
			.lo_port_in  (lo_port_w[i]),
			.tok_out     (tok_w[i+1]),
			.hi_min_out  (hi_min_w[i+1]),
			.hi_port_out (hi_port_w[i+1]),
			.lo_min_out  (lo_min_w[i+1]),
			.lo_port_out (lo_port_w[i+1])
		);
	end

	// end of row: merge the two rotation segments
	assign tok_end = tok_w[MAX_NEIGHBORS];
	assign pick_hi = tok_end.hi_valid &&
		(!tok_end.lo_valid || hi_min_w[MAX_NEIGHBORS] <= lo_min_w[MAX_NEIGHBORS]);
	assign any_end = tok_end.hi_valid || tok_end.lo_valid;

	assign rot_inc  = NW'(rot_q) + NW'(1);
	assign rot_next = (rot_inc == n_q) ? '0 : RW'(rot_inc);

	always_comb begin
		cplt_n = complete_q;
		case (kind_q)
			plls_pkg::KIND_START: begin
				cplt_n = 1'b0;
			end
			plls_pkg::KIND_RESPONSE: begin
				if (tok_end.found && !complete_q) begin
					cplt_n = tok_end.all_ans;
				end
			end
			plls_pkg::KIND_FORCE: begin
				cplt_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign emit_go  = (state_q == ST_EMIT) && (!ovalid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= plls_pkg::KIND_START;
			n_q        <= NW'(1);
			rot_q      <= '0;
			complete_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (emit_go) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= plls_pkg::kind_t'(kind);
						n_q     <= n_clamp;
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (wrap_need) begin
						rot_q <= RW'(NW'(rot_q) - n_q);
					end else begin
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (tok_end.valid) begin
						complete_q <= cplt_n;
						if (kind_q == plls_pkg::KIND_SELECT) begin
							rot_q <= rot_next;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_entry_q <= entry_index;
			item_port_q  <= port_id;
			item_load_q  <= load_value;
		end
		if ((state_q == ST_PASS) && tok_end.valid) begin
			res_lvalid_q <= any_end;
			res_load_q   <= !any_end ? '0 :
				(pick_hi ? hi_min_w[MAX_NEIGHBORS] : lo_min_w[MAX_NEIGHBORS]);
			res_cvalid_q <= (kind_q == plls_pkg::KIND_SELECT) && any_end;
			res_port_q   <= !((kind_q == plls_pkg::KIND_SELECT) && any_end) ? '0 :
				(pick_hi ? hi_port_w[MAX_NEIGHBORS] : lo_port_w[MAX_NEIGHBORS]);
		end
		if (emit_go) begin
			probe_complete_q <= complete_q;
			lowest_load_q    <= res_load_q;
			lowest_valid_q   <= res_lvalid_q;
			chosen_port_q    <= res_port_q;
			chosen_valid_q   <= res_cvalid_q;
		end
	end

	assign out_valid      = ovalid_q;
	assign probe_complete = probe_complete_q;
	assign lowest_load    = lowest_load_q;
	assign lowest_valid   = lowest_valid_q;
	assign chosen_port    = chosen_port_q;
	assign chosen_valid   = chosen_valid_q;

`ifndef SYNTH
	a_tok_end_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.valid |-> state_q == ST_PASS)
		else $error("token left the cell row outside the pass state");

	a_rot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS) && tok_end.valid && (kind_q == plls_pkg::KIND_SELECT)
		|=> NW'(rot_q) < n_q)
		else $error("rotation not below slot count after select");

	a_chosen_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chosen_valid |-> lowest_valid)
		else $error("chosen port without an answered minimum");

	a_no_load_without_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lowest_valid |-> lowest_load == '0)
		else $error("lowest load nonzero with no answers");
`endif

endmodule

### tb/plls_checker.sv
// Checker for probe_least_loaded_selector: watches the APB port and both word channels,
// keeps its own copy of the slot tables and predicts each result word, then compares.
// Depends on plls_pkg.
module plls_checker #(
	parameter int MAX_NEIGHBORS = 8,
	parameter int PORT_BITS     = 16,
	parameter int LOAD_BITS     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [plls_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [plls_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [plls_pkg::KIND_W-1:0]     kind,
	input  logic [plls_pkg::ENTRY_W-1:0]    entry_index,
	input  logic [PORT_BITS-1:0]            port_id,
	input  logic [LOAD_BITS-1:0]            load_value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            probe_complete,
	input  logic [LOAD_BITS-1:0]            lowest_load,
	input  logic                            lowest_valid,
	input  logic [PORT_BITS-1:0]            chosen_port,
	input  logic                            chosen_valid,
	output int                              errors,
	output int                              outstanding
);

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic                 complete;
		logic [LOAD_BITS-1:0] low_load;
		logic                 low_ok;
		logic [PORT_BITS-1:0] port;
		logic                 port_ok;
	} status_t;

	logic [PORT_BITS-1:0]          port_tab [MAX_NEIGHBORS];
	logic [LOAD_BITS-1:0]          load_tab [MAX_NEIGHBORS];
	logic                          answered [MAX_NEIGHBORS];
	logic                          complete;
	int unsigned                   rot;
	logic [plls_pkg::NUM_NB_W-1:0] num_nb;
	status_t                       status_q [$];
	int                            words_seen;

	function automatic int unsigned slots_in_use();
		if (num_nb == 0)
			return 1;
		if (num_nb > MAX_NEIGHBORS)
			return MAX_NEIGHBORS;
		return num_nb;
	endfunction

	function automatic logic min_answered(input int unsigned n, output logic [LOAD_BITS-1:0] m);
		logic any;
		any = 1'b0;
		m = '0;
		for (int j = 0; j < n; j++)
			if (answered[j] && (!any || load_tab[j] < m)) begin
				m = load_tab[j];
				any = 1'b1;
			end
		return any;
	endfunction

	function automatic status_t apply_word(input logic [plls_pkg::KIND_W-1:0] k,
			input logic [plls_pkg::ENTRY_W-1:0] slot, input logic [PORT_BITS-1:0] p,
			input logic [LOAD_BITS-1:0] l);
		int unsigned n, hit, start, idx;
		logic all_in;
		logic [LOAD_BITS-1:0] m;
		status_t s;
		n = slots_in_use();
		s = '0;
		case (k)
			plls_pkg::KIND_START: begin
				for (int j = 0; j < MAX_NEIGHBORS; j++)
					answered[j] = 1'b0;
				complete = 1'b0;
			end
			plls_pkg::KIND_SET_PORT: begin
				if (slot < MAX_NEIGHBORS)
					port_tab[slot] = p;
			end
			plls_pkg::KIND_RESPONSE: begin
				hit = n;
				for (int j = 0; j < n; j++)
					if (hit == n && port_tab[j] == p)
						hit = j;
				if (hit < n) begin
					load_tab[hit] = l;
					answered[hit] = 1'b1;
					if (!complete) begin
						all_in = 1'b1;
						for (int j = 0; j < n; j++)
							if (!answered[j])
								all_in = 1'b0;
						complete = all_in;
					end
				end
			end
			plls_pkg::KIND_FORCE: begin
				complete = 1'b1;
			end
			plls_pkg::KIND_SELECT: begin
				start = rot % n;
				if (min_answered(n, m))
					for (int j = 0; j < n; j++) begin
						idx = (start + j) % n;
						if (!s.port_ok && answered[idx] && load_tab[idx] == m) begin
							s.port = port_tab[idx];
							s.port_ok = 1'b1;
						end
					end
				rot = (start + 1) % n;
			end
			default: ;
		endcase
		s.low_ok = min_answered(n, m);
		s.low_load = s.low_ok ? m : '0;
		s.complete = complete;
		return s;
	endfunction

	task automatic report(input string msg);
		if (errors < MAX_PRINTED)
			$display("plls_checker: word %0d: %s", words_seen, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t exp_s;
		if (!arst_n) begin
			for (int j = 0; j < MAX_NEIGHBORS; j++)
				answered[j] = 1'b0;
			complete = 1'b0;
			rot = 0;
			num_nb = plls_pkg::NUM_NB_RESET;
			status_q.delete();
			words_seen = 0;
			errors = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr[2] == plls_pkg::CFG_REG_NUM_NEIGHBORS)
				num_nb = pwdata[plls_pkg::NUM_NB_W-1:0];
			if (in_valid && !in_stall)
				status_q.push_back(apply_word(kind, entry_index, port_id, load_value));
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					exp_s = status_q.pop_front();
					if (probe_complete !== exp_s.complete)
						report($sformatf("probe_complete %b, expected %b",
							probe_complete, exp_s.complete));
					if (lowest_load !== exp_s.low_load)
						report($sformatf("lowest_load %h, expected %h",
							lowest_load, exp_s.low_load));
					if (lowest_valid !== exp_s.low_ok)
						report($sformatf("lowest_valid %b, expected %b",
							lowest_valid, exp_s.low_ok));
					if (chosen_port !== exp_s.port)
						report($sformatf("chosen_port %h, expected %h",
							chosen_port, exp_s.port));
					if (chosen_valid !== exp_s.port_ok)
						report($sformatf("chosen_valid %b, expected %b",
							chosen_valid, exp_s.port_ok));
				end
				words_seen++;
			end
			outstanding = status_q.size();
		end
	end

endmodule

### tb/tb_probe_least_loaded_selector.sv
// Top of the probe_least_loaded_selector testbench: clock, reset, APB writes and word
// traffic with random gaps and output stalls; plls_checker judges the results.
// Depends on plls_pkg, plls_checker and the block itself.
module tb_probe_least_loaded_selector;

	localparam int MAX_NB        = 8;
	localparam int PORT_BITS     = 16;
	localparam int LOAD_BITS     = 16;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int PHASES        = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [plls_pkg::CFG_ADDR_W-1:0] ADDR_NUM_NB =
		{plls_pkg::CFG_REG_NUM_NEIGHBORS, 2'b00};
	localparam logic [plls_pkg::KIND_W-1:0]     KIND_SPARE_LO = 3'd5;
	localparam logic [plls_pkg::KIND_W-1:0]     KIND_SPARE_HI = 3'd7;

	logic                              clk         = 1'b0;
	logic                              arst_n      = 1'b0;
	logic                              psel        = 1'b0;
	logic                              penable     = 1'b0;
	logic                              pwrite      = 1'b0;
	logic [plls_pkg::CFG_ADDR_W-1:0]   paddr       = '0;
	logic [plls_pkg::CFG_DATA_W-1:0]   pwdata      = '0;
	logic [plls_pkg::CFG_DATA_W-1:0]   prdata;
	logic                              pready;
	logic                              in_valid    = 1'b0;
	logic                              in_stall;
	logic [plls_pkg::KIND_W-1:0]       kind        = '0;
	logic [plls_pkg::ENTRY_W-1:0]      entry_index = '0;
	logic [PORT_BITS-1:0]              port_id     = '0;
	logic [LOAD_BITS-1:0]              load_value  = '0;
	logic                              out_valid;
	logic                              out_stall   = 1'b0;
	logic                              probe_complete;
	logic [LOAD_BITS-1:0]              lowest_load;
	logic                              lowest_valid;
	logic [PORT_BITS-1:0]              chosen_port;
	logic                              chosen_valid;

	int                                mismatch_count;
	int                                words_pending;
	int                                cycles = 0;
	int                                items_sent = 0;
	int                                burst_left = 0;
	int unsigned                       nb_eff = 1;
	logic [PORT_BITS-1:0]              port_shadow [MAX_NB];

	probe_least_loaded_selector #(
		.MAX_NEIGHBORS(MAX_NB),
		.PORT_BITS    (PORT_BITS),
		.LOAD_BITS    (LOAD_BITS)
	) u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .kind, .entry_index, .port_id, .load_value,
		.out_valid, .out_stall, .probe_complete, .lowest_load, .lowest_valid,
		.chosen_port, .chosen_valid
	);

	plls_checker #(
		.MAX_NEIGHBORS(MAX_NB),
		.PORT_BITS    (PORT_BITS),
		.LOAD_BITS    (LOAD_BITS)
	) u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.in_valid, .in_stall, .kind, .entry_index, .port_id, .load_value,
		.out_valid, .out_stall, .probe_complete, .lowest_load, .lowest_valid,
		.chosen_port, .chosen_valid,
		.errors     (mismatch_count),
		.outstanding(words_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: stall pattern in segments, with an occasional long hold
	initial begin : receiver
		int unsigned seg, mode, len;
		seg = 0;
		forever begin
			mode = $urandom_range(0, 15);
			len = $urandom_range(10, 150);
			if (seg == 3 || mode == 15) begin
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end else begin
				repeat (len) begin
					if (mode < 5)
						out_stall <= 1'b0;
					else if (mode < 10)
						out_stall <= ($urandom_range(0, 3) == 0);
					else
						out_stall <= ($urandom_range(0, 3) != 0);
					@(negedge clk);
				end
			end
			seg++;
		end
	end

	// called and returns at a falling edge
	task automatic send_word(input logic [plls_pkg::KIND_W-1:0] k,
			input logic [plls_pkg::ENTRY_W-1:0] e,
			input logic [PORT_BITS-1:0] p, input logic [LOAD_BITS-1:0] l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		in_valid    <= 1'b1;
		kind        <= k;
		entry_index <= e;
		port_id     <= p;
		load_value  <= l;
		if (k == plls_pkg::KIND_SET_PORT)
			port_shadow[e] = p;
		items_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [plls_pkg::CFG_ADDR_W-1:0] a,
			input logic [plls_pkg::CFG_DATA_W-1:0] d);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == ADDR_NUM_NB)
			nb_eff = (d[plls_pkg::NUM_NB_W-1:0] == '0) ? 1
				: (int'(d[plls_pkg::NUM_NB_W-1:0]) > MAX_NB) ? MAX_NB
				: int'(d[plls_pkg::NUM_NB_W-1:0]);
	endtask

	function automatic logic [LOAD_BITS-1:0] rand_load();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return LOAD_BITS'($urandom_range(0, 3));
			default: return LOAD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [PORT_BITS-1:0] fresh_port();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return port_shadow[$urandom_range(0, MAX_NB - 1)];
			default: return PORT_BITS'($urandom);
		endcase
	endfunction

	task automatic run_probe();
		int unsigned nset, nresp, r;
		send_word(plls_pkg::KIND_START, plls_pkg::ENTRY_W'($urandom), PORT_BITS'($urandom),
			LOAD_BITS'($urandom));
		nset = $urandom_range(0, 2);
		repeat (nset)
			send_word(plls_pkg::KIND_SET_PORT, plls_pkg::ENTRY_W'($urandom), fresh_port(),
				LOAD_BITS'($urandom));
		nresp = $urandom_range(1, nb_eff + 2);
		repeat (nresp) begin
			r = $urandom_range(0, 15);
			if (r == 0)
				send_word(plls_pkg::KIND_FORCE, plls_pkg::ENTRY_W'($urandom),
					PORT_BITS'($urandom), rand_load());
			else if (r == 1)
				send_word(plls_pkg::KIND_RESPONSE, plls_pkg::ENTRY_W'($urandom),
					PORT_BITS'($urandom), rand_load());
			else if (r == 2)
				send_word(plls_pkg::KIND_SELECT, plls_pkg::ENTRY_W'($urandom),
					PORT_BITS'($urandom), rand_load());
			else if (r == 3)
				send_word(port_shadow[$urandom_range(0, MAX_NB - 1)] == '0 ? KIND_SPARE_LO
					: plls_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
					plls_pkg::ENTRY_W'($urandom), PORT_BITS'($urandom), rand_load());
			else if (r == 4)
				send_word(plls_pkg::KIND_RESPONSE, plls_pkg::ENTRY_W'($urandom),
					port_shadow[$urandom_range(0, MAX_NB - 1)], rand_load());
			else
				send_word(plls_pkg::KIND_RESPONSE, plls_pkg::ENTRY_W'($urandom),
					port_shadow[$urandom_range(0, nb_eff - 1)], rand_load());
		end
		repeat ($urandom_range(1, 4))
			send_word(plls_pkg::KIND_SELECT, plls_pkg::ENTRY_W'($urandom),
				PORT_BITS'($urandom), rand_load());
	endtask

	initial begin : stimulus
		int unsigned target, nb_pick;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one slot in use: fill the whole port table first, with a duplicate pair
		send_word(plls_pkg::KIND_SET_PORT, 3'd0, 16'h0000, '1);
		send_word(plls_pkg::KIND_SET_PORT, 3'd1, 16'hFFFF, '0);
		send_word(plls_pkg::KIND_SET_PORT, 3'd2, 16'h1234, '1);
		send_word(plls_pkg::KIND_SET_PORT, 3'd3, 16'h1234, '0);
		send_word(plls_pkg::KIND_SET_PORT, 3'd4, 16'h00A5, '1);
		send_word(plls_pkg::KIND_SET_PORT, 3'd5, 16'h5A00, '0);
		send_word(plls_pkg::KIND_SET_PORT, 3'd6, 16'h8001, '1);
		send_word(plls_pkg::KIND_SET_PORT, 3'd7, 16'h7FFE, '0);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'h0000, 16'hFFFF);
		send_word(plls_pkg::KIND_SELECT, 3'd7, '1, '1);
		send_word(KIND_SPARE_LO, 3'd5, '1, '1);
		send_word(KIND_SPARE_HI, 3'd2, '0, '0);
		settle();
		cfg_write(ADDR_NUM_NB, 32'd8);

		// full row: unknown port, duplicate, repeat answer, tie on the minimum
		send_word(plls_pkg::KIND_START, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'hBEEF, 16'h0001);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'h1234, 16'h0100);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'h1234, 16'h0000);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'hFFFF, 16'h0000);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_FORCE, 3'd0, '0, '0);
		send_word(plls_pkg::KIND_START, 3'd0, '0, '0);
		settle();
		cfg_write(ADDR_NUM_NB, 32'd0);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);
		settle();
		cfg_write(ADDR_NUM_NB, 32'd15);
		send_word(plls_pkg::KIND_RESPONSE, 3'd0, 16'h8001, 16'hFFFF);
		send_word(plls_pkg::KIND_SELECT, 3'd0, '0, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: nb_pick = MAX_NB;
				1: nb_pick = 1;
				2: nb_pick = 0;
				3: nb_pick = 15;
				default: nb_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(1, MAX_NB);
			endcase
			cfg_write(ADDR_NUM_NB, nb_pick);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 7) == 0)
					send_word(plls_pkg::KIND_W'($urandom), plls_pkg::ENTRY_W'($urandom),
						PORT_BITS'($urandom), LOAD_BITS'($urandom));
				else
					run_probe();
			end
		end

		settle();
		if (mismatch_count == 0 && words_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
